>>> rtl/assert_macros.svh
// Assertion macros used by the engine module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/sha1s_pkg.sv
// Package with the types, constants and helpers of the SHA-1 stream hasher.
package sha1s_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int BLOCK_BITS   = 512;
	localparam int DIGEST_WORDS = 5;
	localparam int LAST_ROUND   = 79;
	localparam int LAST_IDX     = DIGEST_WORDS - 1;

	// Byte position in a block at which the length field starts (448 / 8).
	localparam logic [5:0] PAD_FILL  = 6'(448 / 8);
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [2:0] LEN_LAST  = 3'd7;
	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

	// Initial chaining value, word 0 in the lowest position.
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} q_entry_t;

	typedef struct packed {
		logic valid;
		logic final_blk;
	} blk_ctl_t;

	typedef enum logic [1:0] {
		PAD_IDLE,
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN
	} pad_state_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_ROUND,
		ENG_FOLD
	} eng_state_t;

endpackage

>>> rtl/sha1s_front.sv
// Front end: accepts input transfers, drops empty ones and queues the rest.
module sha1s_front #(
	parameter int QUEUE_DEPTH = sha1s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_has_byte,
	input  logic                s_tlast,
	output logic                q_valid,
	output sha1s_pkg::q_entry_t q_entry,
	input  logic                q_pop
);
	import sha1s_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push;
	logic               pop;

	assign s_tready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready && (s_has_byte || s_tlast);
	assign pop      = q_pop && q_valid;
	assign q_valid  = (cnt_q != '0);
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_byte: s_tdata, has_byte: s_has_byte,
				end_of_message: s_tlast};
		end
	end

endmodule

>>> rtl/sha1s_pad.sv
// Block collector with the padding and length sequencer.
module sha1s_pad (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sha1s_pkg::q_entry_t q_entry,
	output logic                q_pop,
	output sha1s_pkg::blk_ctl_t blk_ctl,
	output logic [511:0]        blk_data,
	input  logic                blk_take
);
	import sha1s_pkg::*;

	pad_state_t   pad_q;
	pad_state_t   pad_nxt;
	logic [5:0]   fill_q;
	logic         blk_full_q;
	logic         blk_final_q;
	logic [511:0] blk_q;
	logic [60:0]  byte_cnt_q;
	logic [60:0]  byte_cnt_nxt;
	logic [63:0]  len_q;
	logic [2:0]   len_cnt_q;
	logic         push_ok;
	logic         push_en;
	logic [7:0]   push_byte;
	logic         last_len;

	assign push_ok      = !blk_full_q;
	assign byte_cnt_nxt = byte_cnt_q + 61'(q_entry.has_byte);
	assign blk_ctl      = '{valid: blk_full_q, final_blk: blk_final_q};
	assign blk_data     = blk_q;

	always_comb begin
		pad_nxt = pad_q;
		case (pad_q)
			PAD_IDLE: begin
				if (q_pop && q_entry.end_of_message) begin
					pad_nxt = PAD_MARK;
				end
			end
			PAD_MARK: begin
				if (push_ok) begin
					pad_nxt = PAD_ZERO;
				end
			end
			PAD_ZERO: begin
				if (fill_q == PAD_FILL) begin
					pad_nxt = PAD_LEN;
				end
			end
			PAD_LEN: begin
				if (push_ok && len_cnt_q == LEN_LAST) begin
					pad_nxt = PAD_IDLE;
				end
			end
			default: pad_nxt = PAD_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		push_en   = 1'b0;
		push_byte = 8'h00;
		last_len  = 1'b0;
		case (pad_q)
			PAD_IDLE: begin
				if (q_valid && (!q_entry.has_byte || push_ok)) begin
					q_pop     = 1'b1;
					push_en   = q_entry.has_byte;
					push_byte = q_entry.data_byte;
				end
			end
			PAD_MARK: begin
				push_en   = push_ok;
				push_byte = PAD_MARK_BYTE;
			end
			PAD_ZERO: begin
				push_en = push_ok && (fill_q != PAD_FILL);
			end
			PAD_LEN: begin
				push_en   = push_ok;
				push_byte = len_q[63:56];
				last_len  = (len_cnt_q == LEN_LAST);
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q      <= PAD_IDLE;
			fill_q     <= '0;
			blk_full_q <= 1'b0;
			byte_cnt_q <= '0;
			len_cnt_q  <= '0;
		end else begin
			pad_q <= pad_nxt;
			if (push_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (push_en && fill_q == FILL_LAST) begin
				blk_full_q <= 1'b1;
			end else if (blk_take) begin
				blk_full_q <= 1'b0;
			end
			if (q_pop && q_entry.end_of_message) begin
				byte_cnt_q <= '0;
			end else if (q_pop) begin
				byte_cnt_q <= byte_cnt_nxt;
			end
			if (pad_q == PAD_LEN && push_en) begin
				len_cnt_q <= len_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q <= {blk_q[503:0], push_byte};
		end
		if (push_en && fill_q == FILL_LAST) begin
			blk_final_q <= last_len;
		end
		if (q_pop && q_entry.end_of_message) begin
			len_q <= {byte_cnt_nxt, 3'b000};
		end else if (pad_q == PAD_LEN && push_en) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

endmodule

>>> rtl/sha1s_engine.sv
// Compression engine with the chaining value and the digest output register.
`include "assert_macros.svh"

module sha1s_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  sha1s_pkg::blk_ctl_t blk_ctl,
	input  logic [511:0]        blk_data,
	output logic                blk_take,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,
	output logic                m_tlast
);
	import sha1s_pkg::*;

	eng_state_t        eng_q;
	eng_state_t        eng_nxt;
	logic [6:0]        rnd_q;
	logic              fin_q;
	logic [4:0][31:0]  h_q;
	logic [4:0][31:0]  rr_q;
	logic [15:0][31:0] w_q;
	logic [4:0][31:0]  dig_q;
	logic [4:0][31:0]  h_sum;
	logic [2:0]        dig_cnt_q;
	logic [2:0]        idx_q;
	logic [31:0]       f;
	logic [31:0]       k;
	logic [31:0]       tmp;
	logic [31:0]       w_mix;
	logic [31:0]       w_new;
	logic              m_fire;

	assign m_fire   = m_tvalid && m_tready;
	assign m_tvalid = (dig_cnt_q != '0);
	assign m_tdata  = {5'b00000, idx_q, dig_q[0]};
	assign m_tlast  = (idx_q == 3'(LAST_IDX));

	always_comb begin
		eng_nxt = eng_q;
		case (eng_q)
			ENG_IDLE: begin
				if (blk_take) begin
					eng_nxt = ENG_ROUND;
				end
			end
			ENG_ROUND: begin
				if (rnd_q == 7'(LAST_ROUND)) begin
					eng_nxt = ENG_FOLD;
				end
			end
			ENG_FOLD: eng_nxt = ENG_IDLE;
			default:  eng_nxt = ENG_IDLE;
		endcase
	end

	always_comb begin
		blk_take = (eng_q == ENG_IDLE) && blk_ctl.valid
			&& (!blk_ctl.final_blk || dig_cnt_q == '0);
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (rr_q[1] & rr_q[2]) | (~rr_q[1] & rr_q[3]);
			k = K_0;
		end else if (rnd_q < 7'd40) begin
			f = rr_q[1] ^ rr_q[2] ^ rr_q[3];
			k = K_1;
		end else if (rnd_q < 7'd60) begin
			f = (rr_q[1] & rr_q[2]) | (rr_q[1] & rr_q[3]) | (rr_q[2] & rr_q[3]);
			k = K_2;
		end else begin
			f = rr_q[1] ^ rr_q[2] ^ rr_q[3];
			k = K_3;
		end
		tmp   = {rr_q[0][26:0], rr_q[0][31:27]} + f + rr_q[4] + k + w_q[0];
		w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_mix[30:0], w_mix[31]};
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			h_sum[i] = h_q[i] + rr_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_q     <= ENG_IDLE;
			rnd_q     <= '0;
			fin_q     <= 1'b0;
			h_q       <= H_INIT;
			dig_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			eng_q <= eng_nxt;
			if (blk_take) begin
				rnd_q <= '0;
				fin_q <= blk_ctl.final_blk;
			end else if (eng_q == ENG_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (eng_q == ENG_FOLD) begin
				h_q <= fin_q ? H_INIT : h_sum;
			end
			if (eng_q == ENG_FOLD && fin_q) begin
				dig_cnt_q <= 3'(DIGEST_WORDS);
				idx_q     <= '0;
			end else if (m_fire) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
				idx_q     <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (blk_take) begin
			rr_q <= h_q;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_data[BLOCK_BITS - 1 - 32 * i -: 32];
			end
		end else if (eng_q == ENG_ROUND) begin
			rr_q[4] <= rr_q[3];
			rr_q[3] <= rr_q[2];
			rr_q[2] <= {rr_q[1][1:0], rr_q[1][31:2]};
			rr_q[1] <= rr_q[0];
			rr_q[0] <= tmp;
			w_q     <= {w_new, w_q[15:1]};
		end
		if (eng_q == ENG_FOLD && fin_q) begin
			dig_q <= h_sum;
		end else if (m_fire) begin
			dig_q <= {32'h0, dig_q[4:1]};
		end
	end

	`ASSERT_CLK(a_dig_free, (eng_q == ENG_FOLD && fin_q) |-> (dig_cnt_q == '0), "digest over pending words")
	`ASSERT_CLK(a_take_start, blk_take |=> (eng_q == ENG_ROUND && rnd_q == '0), "block start lost")
	`ASSERT_CLK(a_round_range, (eng_q == ENG_ROUND) |-> (rnd_q <= 7'(LAST_ROUND)), "round out of range")
	`ASSERT_NEVER(a_idx_range, m_tvalid && (idx_q > 3'(LAST_IDX)), "digest index out of range")

endmodule

>>> rtl/sha1_stream_hasher.sv
// Top level of the SHA-1 stream hasher.
//
// Input channel s_*: one transfer carries an optional message byte in s_tdata,
// s_tuser[0] says whether that byte belongs to the message, and s_tlast ends
// the message after it. Transfers with neither byte nor end are dropped.
// Output channel m_*: five transfers per message, the digest words most
// significant first, with the word index in m_tdata and m_tlast on the fifth.
// Bytes are packed into 64-byte blocks at one byte per cycle, unless a full
// block waits to be taken, while the round unit compresses the previous
// block (load, 80 rounds, fold). A long message is therefore taken at a pace
// set by the round unit; a short queue sits between the front and the packer.
// After the end transfer, padding runs at one byte per cycle while no full block
// waits, up to the next length field; then one or two blocks are compressed.
// Reset returns the chaining value and the byte count to their initial values
// and empties the input queue; after each digest the block restores both itself.
// A stalled receiver holds the digest words; the next message is still taken
// in until its own final block has to wait for the digest to be drained.
module sha1_stream_hasher #(
	parameter int QUEUE_DEPTH = sha1s_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_tuser,  // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast
);
	import sha1s_pkg::*;

	logic         q_valid;
	q_entry_t     q_entry;
	logic         q_pop;
	blk_ctl_t     blk_ctl;
	logic [511:0] blk_data;
	logic         blk_take;

	sha1s_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_has_byte(s_tuser[0]),
		.s_tlast   (s_tlast),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop)
	);

	sha1s_pad u_pad (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.blk_ctl (blk_ctl),
		.blk_data(blk_data),
		.blk_take(blk_take)
	);

	sha1s_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_ctl (blk_ctl),
		.blk_data(blk_data),
		.blk_take(blk_take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
